[design/tcrd_pkg.sv]
// Shared types, constants and helper functions of the text cell RLE decoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tcrd_pkg;

  // Screen geometry
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int ROW_LIMIT   = 25;  // most rows one image can span

  // Field widths
  localparam int CELL_W  = 12;
  localparam int LEN_W   = 7;
  localparam int COUNT_W = 16;
  localparam int ROWS_W  = 5;
  localparam int COL_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int OUT_DATA_W = 40;  // 35 payload bits rounded up to bytes

  // Clamp limits of the window size
  localparam int MAX_WIDTH  = (SCREEN_COLS < 127) ? SCREEN_COLS : 127;
  localparam int MAX_HEIGHT = (SCREEN_ROWS < ROW_LIMIT) ? SCREEN_ROWS : ROW_LIMIT;

  // Default depth of the command queue between parser and filler
  localparam int QUEUE_DEPTH_DEF = 4;

  // Register reset values
  localparam logic [COL_W-1:0]  WIN_COL_RST    = '0;
  localparam logic [ROWS_W-1:0] WIN_ROW_RST    = '0;
  localparam logic [COL_W-1:0]  WIN_WIDTH_RST  = 7'd80;
  localparam logic [ROWS_W-1:0] WIN_HEIGHT_RST = 5'd25;

  // Special code bytes
  localparam logic [BYTE_W-1:0] CODE_STRING = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_RUN    = 8'hff;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIN_COL    = 2'd0,
    CFG_WIN_ROW    = 2'd1,
    CFG_WIN_WIDTH  = 2'd2,
    CFG_WIN_HEIGHT = 2'd3
  } cfg_reg_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_CODE      = 3'd0,
    PH_STR_CHAR  = 3'd1,
    PH_STR_ATTR  = 3'd2,
    PH_RUN_CHAR  = 3'd3,
    PH_RUN_ATTR  = 3'd4,
    PH_RUN_HI    = 3'd5,
    PH_RUN_LO    = 3'd6,
    PH_PAIR_ATTR = 3'd7
  } phase_t;

  // Window registers
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROWS_W-1:0] row;
    logic [COL_W-1:0]  width;
    logic [ROWS_W-1:0] height;
  } win_cfg_t;

  // Command handed from parser to filler
  typedef struct packed {
    logic               restart;  // reload window start before the fill
    logic               fill;     // count/chr/attr are meaningful
    logic [COUNT_W-1:0] count;    // nonzero when fill is set
    logic [BYTE_W-1:0]  chr;
    logic [BYTE_W-1:0]  attr;
  } fill_cmd_t;

  // Window width with zero and oversize values clamped
  function automatic logic [COL_W-1:0] eff_width(input logic [COL_W-1:0] w);
    logic [COL_W-1:0] r;
    r = w;
    if (w == '0) r = COL_W'(1);
    else if (int'(w) > MAX_WIDTH) r = COL_W'(MAX_WIDTH);
    return r;
  endfunction

  // Window height with zero and oversize values clamped
  function automatic logic [ROWS_W-1:0] eff_height(input logic [ROWS_W-1:0] h);
    logic [ROWS_W-1:0] r;
    r = h;
    if (h == '0) r = ROWS_W'(1);
    else if (int'(h) > MAX_HEIGHT) r = ROWS_W'(MAX_HEIGHT);
    return r;
  endfunction

  // Top-left cell of the window, modulo 4096
  function automatic logic [CELL_W-1:0] win_origin(input logic [COL_W-1:0] col,
                                                   input logic [ROWS_W-1:0] row);
    logic [CELL_W+1:0] sum;
    sum = (CELL_W+2)'(row) * (CELL_W+2)'(SCREEN_COLS) + (CELL_W+2)'(col);
    return sum[CELL_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/text_cell_rle_decoder.sv]
// Text cell run-length decoder, top level: window registers, parser, queue
// and filler. Depends on tcrd_pkg, tcrd_parser, tcrd_fifo and tcrd_filler.
//
// Usage:
//   in_*  : one coded byte per request (tdata) with a restart flag (tuser).
//   out_* : one fill segment per request: start cell, length, character and
//           attribute in tdata; tlast marks the final segment of a byte,
//           tuser marks the segment that fills the last window cell.
//   cfg_* : window register writes (column, row, width, height), taken
//           every cycle; write only while the decoder is idle.
// Throughput: the parser takes one byte per cycle while the command queue
//   has room. The filler loads each fill from the queue and then emits its
//   row segments in order; it loads no new fill until it has emitted the last.
// Path: a byte that fills cells is written to the command queue, loaded into
//   the filler and then registered in the segment output register.
// Reset: window registers return to full screen and decoding restarts at its
//   top-left cell. When out_tready is low, the held segment stays put, the
//   filler stops and the queue fills until in_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module text_cell_rle_decoder #(
  parameter int QUEUE_DEPTH = tcrd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] first_byte
  // segment stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [11:0] cell_index, [18:12] seg_length,
                                       // [26:19] cell_char, [34:27] cell_attr
  output logic             out_tlast,  // last_of_run
  output logic             out_tuser,  // [0] image_done
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);
  import tcrd_pkg::*;

  win_cfg_t    cfg_r, cfg_nxt;
  logic        q_full;
  logic        q_push;
  fill_cmd_t   q_wr;
  logic        q_pop;
  logic        q_valid;
  fill_cmd_t   q_rd;
  logic [CELL_W-1:0] seg_cell;
  logic [LEN_W-1:0]  seg_len;
  logic [BYTE_W-1:0] seg_chr;
  logic [BYTE_W-1:0] seg_attr;

  assign cfg_ready = 1'b1;

  // Window register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_WIN_COL:    cfg_nxt.col    = cfg_data;
        CFG_WIN_ROW:    cfg_nxt.row    = cfg_data[ROWS_W-1:0];
        CFG_WIN_WIDTH:  cfg_nxt.width  = cfg_data;
        CFG_WIN_HEIGHT: cfg_nxt.height = cfg_data[ROWS_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.col    <= WIN_COL_RST;
      cfg_r.row    <= WIN_ROW_RST;
      cfg_r.width  <= WIN_WIDTH_RST;
      cfg_r.height <= WIN_HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcrd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_first (in_tuser),
    .in_ready (in_tready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_wr)
  );

  tcrd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd)
  );

  tcrd_filler u_filler (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (q_valid),
    .cmd       (q_rd),
    .cmd_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cell  (seg_cell),
    .out_len   (seg_len),
    .out_chr   (seg_chr),
    .out_attr  (seg_attr),
    .out_last  (out_tlast),
    .out_done  (out_tuser)
  );

  assign out_tdata = {5'b0, seg_attr, seg_chr, seg_len, seg_cell};

endmodule

`default_nettype wire

[design/tcrd_parser.sv]
// Front end of the text cell RLE decoder: parses code bytes into fill commands.
// Depends on tcrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcrd_parser (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   in_first,
  output logic                        in_ready,
  input  wire logic                   q_full,
  output logic                        q_push,
  output tcrd_pkg::fill_cmd_t         q_cmd
);
  import tcrd_pkg::*;

  phase_t            phase_r, phase_nxt, phase_cur;
  logic              sm_r, sm_nxt, sm_cur;
  logic [BYTE_W-1:0] hchar_r, hchar_nxt, hchar_cur;
  logic [BYTE_W-1:0] hattr_r, hattr_nxt, hattr_cur;
  logic [BYTE_W-1:0] chi_r, chi_nxt, chi_cur;
  logic              fire;
  logic              fill;
  logic [COUNT_W-1:0] count;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // A first byte parses from the restart state
  always_comb begin
    phase_cur = in_first ? PH_CODE : phase_r;
    sm_cur    = in_first ? 1'b0 : sm_r;
    hchar_cur = in_first ? '0 : hchar_r;
    hattr_cur = in_first ? '0 : hattr_r;
    chi_cur   = in_first ? '0 : chi_r;
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      case (phase_cur)
        PH_CODE: begin
          if (in_byte == CODE_STRING) phase_nxt = sm_cur ? PH_CODE : PH_STR_CHAR;
          else if (in_byte == CODE_RUN) phase_nxt = PH_RUN_CHAR;
          else phase_nxt = sm_cur ? PH_CODE : PH_PAIR_ATTR;
        end
        PH_STR_CHAR:  phase_nxt = PH_STR_ATTR;
        PH_STR_ATTR:  phase_nxt = PH_CODE;
        PH_PAIR_ATTR: phase_nxt = PH_CODE;
        PH_RUN_CHAR:  phase_nxt = PH_RUN_ATTR;
        PH_RUN_ATTR:  phase_nxt = PH_RUN_HI;
        PH_RUN_HI:    phase_nxt = PH_RUN_LO;
        PH_RUN_LO:    phase_nxt = PH_CODE;
        default:      phase_nxt = PH_CODE;
      endcase
    end
  end

  // Held values and command output
  always_comb begin
    sm_nxt    = sm_r;
    hchar_nxt = hchar_r;
    hattr_nxt = hattr_r;
    chi_nxt   = chi_r;
    fill      = 1'b0;
    count     = COUNT_W'(1);
    if (fire) begin
      sm_nxt    = sm_cur;
      hchar_nxt = hchar_cur;
      hattr_nxt = hattr_cur;
      chi_nxt   = chi_cur;
      case (phase_cur)
        PH_CODE: begin
          if (in_byte == CODE_STRING) begin
            sm_nxt = !sm_cur;
          end else if (in_byte != CODE_RUN) begin
            hchar_nxt = in_byte;
            fill      = sm_cur;  // string char uses the held attribute
          end
        end
        PH_STR_CHAR, PH_RUN_CHAR: hchar_nxt = in_byte;
        PH_RUN_ATTR: hattr_nxt = in_byte;
        PH_STR_ATTR, PH_PAIR_ATTR: begin
          hattr_nxt = in_byte;
          fill      = 1'b1;
        end
        PH_RUN_HI: chi_nxt = in_byte;
        PH_RUN_LO: begin
          count = {chi_cur, in_byte};
          fill  = (count != '0);  // empty run emits nothing
        end
        default: fill = 1'b0;
      endcase
    end
  end

  assign q_push        = fire && (in_first || fill);
  assign q_cmd.restart = in_first;
  assign q_cmd.fill    = fill;
  assign q_cmd.count   = count;
  assign q_cmd.chr     = hchar_nxt;
  assign q_cmd.attr    = hattr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CODE;
      sm_r    <= 1'b0;
      hchar_r <= '0;
      hattr_r <= '0;
      chi_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      sm_r    <= sm_nxt;
      hchar_r <= hchar_nxt;
      hattr_r <= hattr_nxt;
      chi_r   <= chi_nxt;
    end
  end

endmodule

`default_nettype wire

[design/tcrd_fifo.sv]
// Command queue between parser and filler of the text cell RLE decoder.
// Depends on tcrd_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module tcrd_fifo #(
  parameter int DEPTH = tcrd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire tcrd_pkg::fill_cmd_t wr_data,
  output logic                     full,
  input  wire logic                pop,
  output logic                     rd_valid,
  output tcrd_pkg::fill_cmd_t      rd_data
);
  import tcrd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fill_cmd_t         mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rd_valid) else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on write");
`endif

endmodule

`default_nettype wire

[design/tcrd_filler.sv]
// Back end of the text cell RLE decoder: walks the window cursor and splits
// fills into row segments. Depends on tcrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcrd_filler (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tcrd_pkg::win_cfg_t    cfg,
  input  wire logic                  cmd_valid,
  input  wire tcrd_pkg::fill_cmd_t   cmd,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [11:0]                out_cell,
  output logic [6:0]                 out_len,
  output logic [7:0]                 out_chr,
  output logic [7:0]                 out_attr,
  output logic                       out_last,
  output logic                       out_done
);
  import tcrd_pkg::*;

  logic               busy_r, busy_nxt;
  logic               fin_r, fin_nxt;
  logic [COUNT_W-1:0] n_r, n_nxt;
  logic [BYTE_W-1:0]  chr_r, chr_nxt;
  logic [BYTE_W-1:0]  attr_r, attr_nxt;
  logic [COL_W-1:0]   cells_r, cells_nxt;
  logic [ROWS_W-1:0]  rows_r, rows_nxt;
  logic [CELL_W-1:0]  cursor_r, cursor_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic [CELL_W-1:0]  ocell_r, ocell_nxt;
  logic [LEN_W-1:0]   olen_r, olen_nxt;
  logic [BYTE_W-1:0]  ochr_r, ochr_nxt;
  logic [BYTE_W-1:0]  oattr_r, oattr_nxt;
  logic               olast_r, olast_nxt;
  logic               odone_r, odone_nxt;

  logic               emit;
  logic [LEN_W-1:0]   seg;
  logic [COL_W-1:0]   cells_after;
  logic               row_end;
  logic               done;
  logic               last;
  logic [CELL_W-1:0]  cursor_step;
  logic [COL_W-1:0]   w_eff;

  // Current segment: up to the end of the window row
  always_comb begin
    w_eff       = eff_width(cfg.width);
    seg         = (n_r < COUNT_W'(cells_r)) ? n_r[LEN_W-1:0] : cells_r;
    cells_after = cells_r - seg;
    row_end     = (cells_after == '0);
    done        = row_end && (rows_r <= ROWS_W'(1));
    last        = (n_r == COUNT_W'(seg)) || done;
    cursor_step = cursor_r + CELL_W'(seg);
    emit        = busy_r && (!ovalid_r || out_ready);
    cmd_pop     = cmd_valid && !busy_r;
  end

  // Next state of cursor, command and output register
  always_comb begin
    busy_nxt   = busy_r;
    fin_nxt    = fin_r;
    n_nxt      = n_r;
    chr_nxt    = chr_r;
    attr_nxt   = attr_r;
    cells_nxt  = cells_r;
    rows_nxt   = rows_r;
    cursor_nxt = cursor_r;
    ovalid_nxt = ovalid_r && !out_ready;
    ocell_nxt  = ocell_r;
    olen_nxt   = olen_r;
    ochr_nxt   = ochr_r;
    oattr_nxt  = oattr_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;
    if (cmd_pop) begin
      n_nxt    = cmd.count;
      chr_nxt  = cmd.chr;
      attr_nxt = cmd.attr;
      busy_nxt = cmd.fill && (cmd.restart || !fin_r);
      if (cmd.restart) begin
        fin_nxt    = 1'b0;
        cells_nxt  = w_eff;
        rows_nxt   = eff_height(cfg.height);
        cursor_nxt = win_origin(cfg.col, cfg.row);
      end
    end else if (emit) begin
      ovalid_nxt = 1'b1;
      ocell_nxt  = cursor_r;
      olen_nxt   = seg;
      ochr_nxt   = chr_r;
      oattr_nxt  = attr_r;
      olast_nxt  = last;
      odone_nxt  = done;
      n_nxt      = n_r - COUNT_W'(seg);
      busy_nxt   = !last;
      cells_nxt  = cells_after;
      cursor_nxt = cursor_step;
      if (row_end) begin
        rows_nxt = rows_r - 1'b1;
        if (done) begin
          fin_nxt = 1'b1;
        end else begin
          // wrap to the next window row
          cells_nxt  = w_eff;
          cursor_nxt = cursor_step + CELL_W'(SCREEN_COLS) - CELL_W'(w_eff);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      fin_r    <= 1'b0;
      cells_r  <= eff_width(WIN_WIDTH_RST);
      rows_r   <= eff_height(WIN_HEIGHT_RST);
      cursor_r <= win_origin(WIN_COL_RST, WIN_ROW_RST);
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      fin_r    <= fin_nxt;
      cells_r  <= cells_nxt;
      rows_r   <= rows_nxt;
      cursor_r <= cursor_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    chr_r   <= chr_nxt;
    attr_r  <= attr_nxt;
    ocell_r <= ocell_nxt;
    olen_r  <= olen_nxt;
    ochr_r  <= ochr_nxt;
    oattr_r <= oattr_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_cell  = ocell_r;
  assign out_len   = olen_r;
  assign out_chr   = ochr_r;
  assign out_attr  = oattr_r;
  assign out_last  = olast_r;
  assign out_done  = odone_r;

`ifndef SYNTHESIS
  a_busy_not_fin: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !fin_r) else $error("filling after window full");
  a_room_left: assert property (@(posedge clk) disable iff (!rst_n)
    !fin_r |-> (cells_r != '0 && rows_r != '0))
    else $error("window counters empty while not finished");
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && done) |=> (fin_r && !busy_r && out_done && out_last))
    else $error("last window cell did not end the image");
`endif

endmodule

`default_nettype wire
